>>> src/gated_hover_throttle_tracker_assert.svh
//------------------------------------------------------------------------------
// gated hover throttle tracker assertion macros
// clocked concurrent checks with active-low reset disable
//------------------------------------------------------------------------------
`ifndef GATED_HOVER_THROTTLE_TRACKER_ASSERT_SVH
`define GATED_HOVER_THROTTLE_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GHTT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the following cycle
`define GHTT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ghtt_pkg.sv
//------------------------------------------------------------------------------
// ghtt_pkg
// shared widths, register codes, reset values and request types
//------------------------------------------------------------------------------
package ghtt_pkg;

    localparam int THR_W      = 16;
    localparam int LIMIT_W    = 15;
    localparam int TILT_W     = 16;
    localparam int TIMER_W    = 24;
    localparam int SLEW_W     = 16;
    localparam int DT_W       = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EST_MIN    = 3'd0,
        REG_EST_MAX    = 3'd1,
        REG_INIT_EST   = 3'd2,
        REG_CLIMB_LIM  = 3'd3,
        REG_ACCEL_LIM  = 3'd4,
        REG_TILT_MIN   = 3'd5,
        REG_SETTLE     = 3'd6,
        REG_SLEW       = 3'd7
    } t_cfg_idx;

    localparam logic [THR_W-1:0]          RST_EST_MIN   = 16'd3277;
    localparam logic [THR_W-1:0]          RST_EST_MAX   = 16'd52429;
    localparam logic [THR_W-1:0]          RST_INIT_EST  = 16'd26214;
    localparam logic [LIMIT_W-1:0]        RST_CLIMB_LIM = 15'd128;
    localparam logic [LIMIT_W-1:0]        RST_ACCEL_LIM = 15'd256;
    localparam logic signed [TILT_W-1:0]  RST_TILT_MIN  = 16'sd16137;
    localparam logic [TIMER_W-1:0]        RST_SETTLE    = 24'd1000000;
    localparam logic [SLEW_W-1:0]         RST_SLEW      = 16'd215;

    // lower bound tested first: an inverted band gives lo below lo, else hi
    function automatic logic [THR_W-1:0] clamp_band(
        input logic [THR_W-1:0] v,
        input logic [THR_W-1:0] lo,
        input logic [THR_W-1:0] hi
    );
        logic [THR_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    localparam logic [THR_W-1:0] RST_EST = clamp_band(RST_INIT_EST, RST_EST_MIN, RST_EST_MAX);

    typedef struct packed {
        logic                      action;
        logic                      in_air;
        logic [THR_W-1:0]          collective;
        logic signed [15:0]        climb_vel;
        logic signed [15:0]        z_accel;
        logic signed [TILT_W-1:0]  tilt_cos;
        logic [DT_W-1:0]           delta_time;
    } t_in_item;

    typedef struct packed {
        logic [THR_W-1:0] thr_est;
        logic             has_measured;
    } t_out_item;

endpackage

>>> src/ghtt_stream_if.sv
//------------------------------------------------------------------------------
// ghtt_stream_if
// valid/ready channel carrying one request payload
//------------------------------------------------------------------------------
interface ghtt_stream_if #(
    parameter type t_data = ghtt_pkg::t_in_item
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> src/gated_hover_throttle_tracker.sv
//------------------------------------------------------------------------------
// gated_hover_throttle_tracker
// gated, slew-limited hover throttle estimate with one result per request
//------------------------------------------------------------------------------
// One request is taken per cycle while the sink takes results. Its steady gates
// and slew step (slew_rate * delta_time) are evaluated as it enters and held in
// the input stage; when the input stage advances, the settle timer, estimate and
// measured flag update together and the result register loads. The result
// register and the input stage each hold a request: while a finished result
// waits for the sink one more request is taken, and then the input stalls until
// the sink takes the result. Configuration writes land at once and must only
// be issued with no request in flight.
//------------------------------------------------------------------------------
`include "gated_hover_throttle_tracker_assert.svh"

module gated_hover_throttle_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ghtt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ghtt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ghtt_stream_if.sink                     i_in,
    ghtt_stream_if.source                   o_out
);

    // configuration registers
    logic [ghtt_pkg::THR_W-1:0]          r_est_min;
    logic [ghtt_pkg::THR_W-1:0]          r_est_max;
    logic [ghtt_pkg::THR_W-1:0]          r_init_est;
    logic [ghtt_pkg::LIMIT_W-1:0]        r_climb_lim;
    logic [ghtt_pkg::LIMIT_W-1:0]        r_accel_lim;
    logic signed [ghtt_pkg::TILT_W-1:0]  r_tilt_min;
    logic [ghtt_pkg::TIMER_W-1:0]        r_settle;
    logic [ghtt_pkg::SLEW_W-1:0]         r_slew;

    // tracker state
    logic [ghtt_pkg::THR_W-1:0]   r_est,   n_est;
    logic                         r_meas,  n_meas;
    logic [ghtt_pkg::TIMER_W-1:0] r_timer, n_timer;

    // input stage
    logic                         r_s1_vld;
    logic                         r_s1_action;
    logic                         r_s1_steady;
    logic [ghtt_pkg::THR_W-1:0]   r_s1_coll;
    logic [ghtt_pkg::DT_W-1:0]    r_s1_dt;
    logic [ghtt_pkg::THR_W-1:0]   r_s1_step;

    // result register
    logic                         r_out_vld;
    ghtt_pkg::t_out_item          r_out_data;

    logic w_adv;
    logic w_in_rdy;
    logic w_in_acc;

    // handshake: stage 1 moves on when the result slot is free or draining
    assign w_adv    = r_s1_vld && (!r_out_vld || o_out.ready);
    assign w_in_rdy = !r_s1_vld || w_adv;
    assign w_in_acc = i_in.valid && w_in_rdy;

    assign i_in.ready  = w_in_rdy;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out_data;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est_min   <= ghtt_pkg::RST_EST_MIN;
            r_est_max   <= ghtt_pkg::RST_EST_MAX;
            r_init_est  <= ghtt_pkg::RST_INIT_EST;
            r_climb_lim <= ghtt_pkg::RST_CLIMB_LIM;
            r_accel_lim <= ghtt_pkg::RST_ACCEL_LIM;
            r_tilt_min  <= ghtt_pkg::RST_TILT_MIN;
            r_settle    <= ghtt_pkg::RST_SETTLE;
            r_slew      <= ghtt_pkg::RST_SLEW;
        end else if (i_cfg_we) begin
            unique case (ghtt_pkg::t_cfg_idx'(i_cfg_idx))
                ghtt_pkg::REG_EST_MIN:   r_est_min   <= i_cfg_data[ghtt_pkg::THR_W-1:0];
                ghtt_pkg::REG_EST_MAX:   r_est_max   <= i_cfg_data[ghtt_pkg::THR_W-1:0];
                ghtt_pkg::REG_INIT_EST:  r_init_est  <= i_cfg_data[ghtt_pkg::THR_W-1:0];
                ghtt_pkg::REG_CLIMB_LIM: r_climb_lim <= i_cfg_data[ghtt_pkg::LIMIT_W-1:0];
                ghtt_pkg::REG_ACCEL_LIM: r_accel_lim <= i_cfg_data[ghtt_pkg::LIMIT_W-1:0];
                ghtt_pkg::REG_TILT_MIN:  r_tilt_min  <= $signed(i_cfg_data[ghtt_pkg::TILT_W-1:0]);
                ghtt_pkg::REG_SETTLE:    r_settle    <= i_cfg_data[ghtt_pkg::TIMER_W-1:0];
                ghtt_pkg::REG_SLEW:      r_slew      <= i_cfg_data[ghtt_pkg::SLEW_W-1:0];
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // stage 1: steady gates and slew step from the raw request
    //--------------------------------------------------------------------------
    logic signed [16:0] w_climb_x;
    logic signed [16:0] w_accel_x;
    logic [16:0]        w_climb_abs;
    logic [16:0]        w_accel_abs;
    logic               w_steady;
    logic [31:0]        w_prod;

    always_comb begin
        w_climb_x = 17'(i_in.data.climb_vel);
        w_accel_x = 17'(i_in.data.z_accel);
        // 17 bits so the most negative input takes its magnitude without wrapping
        w_climb_abs = (w_climb_x < 0) ? 17'(-w_climb_x) : 17'(w_climb_x);
        w_accel_abs = (w_accel_x < 0) ? 17'(-w_accel_x) : 17'(w_accel_x);
        w_steady = i_in.data.in_air
                && (i_in.data.delta_time != '0)
                && (w_climb_abs < {2'b00, r_climb_lim})
                && (w_accel_abs < {2'b00, r_accel_lim})
                && (i_in.data.tilt_cos > r_tilt_min)
                && (i_in.data.collective > r_est_min)
                && (i_in.data.collective < r_est_max);
        // max movement in lsbs, Q16 scaling dropped
        w_prod = 32'(r_slew) * 32'(i_in.data.delta_time);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_rdy) begin
            r_s1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_action <= i_in.data.action;
            r_s1_steady <= w_steady;
            r_s1_coll   <= i_in.data.collective;
            r_s1_dt     <= i_in.data.delta_time;
            r_s1_step   <= w_prod[31:16];
        end
    end

    //--------------------------------------------------------------------------
    // stage 2: timer, slew-limited tracking, band clamp
    //--------------------------------------------------------------------------
    logic [ghtt_pkg::TIMER_W:0]   w_tsum;
    logic [ghtt_pkg::TIMER_W-1:0] w_tsat;
    logic signed [17:0]           w_err;
    logic signed [17:0]           w_step;
    logic signed [17:0]           w_lim;
    logic signed [17:0]           w_sum;
    logic signed [17:0]           w_lo;
    logic signed [17:0]           w_hi;

    always_comb begin
        w_tsum = {1'b0, r_timer} + (ghtt_pkg::TIMER_W+1)'(r_s1_dt);
        // saturate at all ones
        w_tsat = w_tsum[ghtt_pkg::TIMER_W] ? '1 : w_tsum[ghtt_pkg::TIMER_W-1:0];

        w_err  = $signed({2'b00, r_s1_coll}) - $signed({2'b00, r_est});
        w_step = $signed({2'b00, r_s1_step});
        if (w_err > w_step) begin
            w_lim = w_step;
        end else if (w_err < -w_step) begin
            w_lim = -w_step;
        end else begin
            w_lim = w_err;
        end
        w_sum = $signed({2'b00, r_est}) + w_lim;
        w_lo  = $signed({2'b00, r_est_min});
        w_hi  = $signed({2'b00, r_est_max});

        n_est   = r_est;
        n_meas  = r_meas;
        n_timer = r_timer;
        if (r_s1_action) begin
            // reseed from config, sample fields ignored
            n_est   = ghtt_pkg::clamp_band(r_init_est, r_est_min, r_est_max);
            n_meas  = 1'b0;
            n_timer = '0;
        end else if (!r_s1_steady) begin
            n_timer = '0;
        end else begin
            n_timer = w_tsat;
            if (w_tsat >= r_settle) begin
                if (w_sum < w_lo) begin
                    n_est = r_est_min;
                end else if (w_sum > w_hi) begin
                    n_est = r_est_max;
                end else begin
                    n_est = w_sum[ghtt_pkg::THR_W-1:0];
                end
                n_meas = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est     <= ghtt_pkg::RST_EST;
            r_meas    <= 1'b0;
            r_timer   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_est   <= n_est;
                r_meas  <= n_meas;
                r_timer <= n_timer;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.thr_est      <= n_est;
            r_out_data.has_measured <= n_meas;
        end
    end

    //--------------------------------------------------------------------------
    // checks
    //--------------------------------------------------------------------------
    `GHTT_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n,
        r_s1_vld && r_out_vld && !o_out.ready, !i_in.ready,
        "input accepted while both stages are held")
    `GHTT_ASSERT_NOW(a_meas_rises_on_advance, i_clk, i_rst_n,
        $rose(r_meas), $past(w_adv) && !$past(r_s1_action),
        "measured flag set without an update request")
    `GHTT_ASSERT_NEXT(a_reseed_clears, i_clk, i_rst_n,
        w_adv && r_s1_action, (r_timer == '0) && !r_meas && !o_out.data.has_measured,
        "reseed left timer or measured flag set")
    `GHTT_ASSERT_NEXT(a_advance_fills_result, i_clk, i_rst_n,
        w_adv, o_out.valid && (o_out.data.thr_est == r_est),
        "result register does not match updated estimate")

endmodule
